>>> design/imuocc_pkg.sv
// Shared types and constants for the IMU offset calibration and correction block.
`timescale 1ns / 1ps

package imuocc_pkg;

  localparam int SMP_W             = 16;
  localparam int N_AXES            = 3;
  localparam int SAMPLE_BITS       = 2 * N_AXES * SMP_W;
  localparam int CALIB_SAMPLES_DEF = 200;
  localparam int QUEUE_DEPTH       = 4;
  localparam int ONE_G_W           = 15;
  localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd16384;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SKIP,
    ACT_ACC,
    ACT_FIN
  } cal_act_t;

  typedef struct packed {
    cal_act_t gyro_act;
    cal_act_t accel_act;
    logic     gyro_done;
    logic     accel_done;
  } cls_t;

  typedef struct packed {
    cls_t                    cls;
    smp_t [N_AXES-1:0]       gyro;
    smp_t [N_AXES-1:0]       accel;
  } qent_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic accel_sel;
  } div_stat_t;

endpackage

>>> design/imuocc_front.sv
// Front end: tracks calibration progress and classifies each accepted sample set.
`timescale 1ns / 1ps

module imuocc_front import imuocc_pkg::*; #(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output cls_t cls
);

  localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES);

  logic [CNT_W-1:0] gcnt_r, gcnt_nxt;
  logic [CNT_W-1:0] acnt_r, acnt_nxt;
  logic             gdone_r, gdone_nxt;
  logic             adone_r, adone_nxt;
  logic             serve_accel;

  always_comb begin
    gcnt_nxt      = gcnt_r;
    acnt_nxt      = acnt_r;
    gdone_nxt     = gdone_r;
    adone_nxt     = adone_r;
    serve_accel   = 1'b1;
    cls.gyro_act  = ACT_NONE;
    cls.accel_act = ACT_NONE;
    if (!gdone_r) begin
      if (gcnt_r == '0) begin
        cls.gyro_act = ACT_SKIP;
        gcnt_nxt     = CNT_W'(1);
        serve_accel  = 1'b0;
      end else if (gcnt_r == CNT_LAST) begin
        cls.gyro_act = ACT_FIN;
        gcnt_nxt     = '0;
        gdone_nxt    = 1'b1;
        serve_accel  = 1'b0;
      end else begin
        cls.gyro_act = ACT_ACC;
        gcnt_nxt     = gcnt_r + 1'b1;
      end
    end
    if (serve_accel && !adone_r) begin
      if (acnt_r == '0) begin
        cls.accel_act = ACT_SKIP;
        acnt_nxt      = CNT_W'(1);
      end else if (acnt_r == CNT_LAST) begin
        cls.accel_act = ACT_FIN;
        acnt_nxt      = '0;
        adone_nxt     = 1'b1;
      end else begin
        cls.accel_act = ACT_ACC;
        acnt_nxt      = acnt_r + 1'b1;
      end
    end
    cls.gyro_done  = gdone_nxt;
    cls.accel_done = adone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r  <= '0;
      acnt_r  <= '0;
      gdone_r <= 1'b0;
      adone_r <= 1'b0;
    end else if (push) begin
      gcnt_r  <= gcnt_nxt;
      acnt_r  <= acnt_nxt;
      gdone_r <= gdone_nxt;
      adone_r <= adone_nxt;
    end
  end

endmodule

>>> design/imuocc_fifo.sv
// Short queue of classified sample sets between the front and back ends.
`timescale 1ns / 1ps

module imuocc_fifo import imuocc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output qent_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  qent_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/imuocc_div.sv
// Three-lane division of the calibration sums by the sample count, by reciprocal multiplication.
`timescale 1ns / 1ps

module imuocc_div import imuocc_pkg::*; #(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      start,
  input  logic                                                      accel_sel,
  input  logic [N_AXES-1:0][SMP_W+$clog2(CALIB_SAMPLES)-1:0]        sum_in,
  output div_stat_t                                                 stat,
  output smp_t [N_AXES-1:0]                                         quo
);

  // The magnitude of a sum is below 2^SUM_W, so a reciprocal rounded up with
  // SUM_W + clog2(CALIB_SAMPLES) fraction bits gives the exact truncated quotient.
  localparam int SUM_W  = SMP_W + $clog2(CALIB_SAMPLES);
  localparam int SHIFT  = SUM_W + $clog2(CALIB_SAMPLES);
  localparam int RCP_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

  logic              busy_r;
  logic              done_r;
  logic              sel_r;
  logic              neg_r [N_AXES];
  logic [SUM_W-1:0]  mag_r [N_AXES];
  smp_t              qmag_r [N_AXES];
  logic [PROD_W-1:0] prod [N_AXES];

  assign stat.busy      = busy_r;
  assign stat.done      = done_r;
  assign stat.accel_sel = sel_r;

  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      prod[i] = PROD_W'(mag_r[i]) * PROD_W'(RCP);
      quo[i]  = neg_r[i] ? -qmag_r[i] : qmag_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sel_r <= accel_sel;
      for (int i = 0; i < N_AXES; i++) begin
        neg_r[i] <= sum_in[i][SUM_W-1];
        mag_r[i] <= sum_in[i][SUM_W-1] ? -sum_in[i] : sum_in[i];
      end
    end
    if (busy_r) begin
      for (int i = 0; i < N_AXES; i++) begin
        qmag_r[i] <= prod[i][SHIFT +: SMP_W];
      end
    end
  end

endmodule

>>> design/imuocc_back.sv
// Back end: offset correction, calibration sums, offset update and output register.
`timescale 1ns / 1ps

module imuocc_back import imuocc_pkg::*; #(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [ONE_G_W-1:0]     cfg_wdata,
  input  logic                   head_valid,
  input  qent_t                  head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [SAMPLE_BITS-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  localparam int SUM_W = SMP_W + $clog2(CALIB_SAMPLES);

  logic signed [SUM_W-1:0] gsum_r [N_AXES];
  logic signed [SUM_W-1:0] gsum_nxt [N_AXES];
  logic signed [SUM_W-1:0] asum_r [N_AXES];
  logic signed [SUM_W-1:0] asum_nxt [N_AXES];
  logic [N_AXES-1:0][SUM_W-1:0] gsum_add;
  logic [N_AXES-1:0][SUM_W-1:0] asum_add;
  logic [N_AXES-1:0][SUM_W-1:0] div_sum;
  smp_t                    goff_r [N_AXES];
  smp_t                    goff_nxt [N_AXES];
  smp_t                    aoff_r [N_AXES];
  smp_t                    aoff_nxt [N_AXES];
  smp_t                    gcorr [N_AXES];
  smp_t                    acorr [N_AXES];
  logic [SMP_W:0]          zdiff;
  logic [SMP_W:0]          zoff;
  logic [ONE_G_W-1:0]      one_g_r;
  logic [ONE_G_W-1:0]      one_g_snap_r;
  logic                    div_start;
  logic                    div_accel;
  div_stat_t               dstat;
  smp_t [N_AXES-1:0]       quo;
  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  out_data_r;
  logic [1:0]              out_user_r;

  assign pop = head_valid && !dstat.busy && !dstat.done && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      gcorr[i]    = head.gyro[i] - goff_r[i];
      acorr[i]    = head.accel[i] - aoff_r[i];
      gsum_add[i] = gsum_r[i] + {{(SUM_W - SMP_W){head.gyro[i][SMP_W-1]}}, head.gyro[i]};
      asum_add[i] = asum_r[i] + {{(SUM_W - SMP_W){head.accel[i][SMP_W-1]}}, head.accel[i]};
    end
    zdiff = {head.accel[2][SMP_W-1], head.accel[2]} - {aoff_r[2][SMP_W-1], aoff_r[2]};
    if (zdiff[SMP_W] != zdiff[SMP_W-1]) begin
      acorr[2] = zdiff[SMP_W] ? SMP_MIN : SMP_MAX;
    end else begin
      acorr[2] = zdiff[SMP_W-1:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_accel = 1'b0;
    div_sum   = gsum_add;
    for (int i = 0; i < N_AXES; i++) begin
      gsum_nxt[i] = gsum_r[i];
      asum_nxt[i] = asum_r[i];
      goff_nxt[i] = goff_r[i];
      aoff_nxt[i] = aoff_r[i];
    end
    if (pop) begin
      case (head.cls.gyro_act)
        ACT_SKIP: begin
          for (int i = 0; i < N_AXES; i++) begin
            gsum_nxt[i] = '0;
            goff_nxt[i] = '0;
          end
        end
        ACT_ACC: begin
          for (int i = 0; i < N_AXES; i++) begin
            gsum_nxt[i] = gsum_add[i];
          end
        end
        ACT_FIN: begin
          for (int i = 0; i < N_AXES; i++) begin
            gsum_nxt[i] = gsum_add[i];
          end
          div_start = 1'b1;
        end
        default: begin
        end
      endcase
      case (head.cls.accel_act)
        ACT_SKIP: begin
          for (int i = 0; i < N_AXES; i++) begin
            asum_nxt[i] = '0;
            aoff_nxt[i] = '0;
          end
        end
        ACT_ACC: begin
          for (int i = 0; i < N_AXES; i++) begin
            asum_nxt[i] = asum_add[i];
          end
        end
        ACT_FIN: begin
          for (int i = 0; i < N_AXES; i++) begin
            asum_nxt[i] = asum_add[i];
          end
          div_start = 1'b1;
          div_accel = 1'b1;
          div_sum   = asum_add;
        end
        default: begin
        end
      endcase
    end
    zoff = {quo[2][SMP_W-1], quo[2]} - {2'b00, one_g_snap_r};
    if (dstat.done) begin
      if (dstat.accel_sel) begin
        aoff_nxt[0] = quo[0];
        aoff_nxt[1] = quo[1];
        if (zoff[SMP_W] != zoff[SMP_W-1]) begin
          aoff_nxt[2] = zoff[SMP_W] ? SMP_MIN : SMP_MAX;
        end else begin
          aoff_nxt[2] = zoff[SMP_W-1:0];
        end
      end else begin
        for (int i = 0; i < N_AXES; i++) begin
          goff_nxt[i] = quo[i];
        end
      end
    end
  end

  imuocc_div #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .accel_sel (div_accel),
    .sum_in    (div_sum),
    .stat      (dstat),
    .quo       (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_g_r     <= ONE_G_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N_AXES; i++) begin
        gsum_r[i] <= '0;
        asum_r[i] <= '0;
        goff_r[i] <= '0;
        aoff_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        one_g_r <= cfg_wdata;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      for (int i = 0; i < N_AXES; i++) begin
        gsum_r[i] <= gsum_nxt[i];
        asum_r[i] <= asum_nxt[i];
        goff_r[i] <= goff_nxt[i];
        aoff_r[i] <= aoff_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      one_g_snap_r <= one_g_r;
    end
    if (pop) begin
      out_data_r <= {gcorr[2], gcorr[1], gcorr[0], acorr[2], acorr[1], acorr[0]};
      out_user_r <= {head.cls.accel_done, head.cls.gyro_done};
    end
  end

endmodule

>>> design/imu_offset_calibrate_correct.sv
// Top level of the IMU zero-offset calibration and correction block.
//
//  Channel   Ports                          Payload
//  input     in_tvalid/in_tready/in_tdata   six raw samples, 96 bits
//  result    out_tvalid/out_tready/out_*    six corrected samples, two flags
//  config    cfg_we/cfg_wdata               one-g reading, 15 bits
//
// One sample set per cycle while the queue is not full; results are registered.
// After the transfer that completes a calibration, the divider holds
// the back end while it is busy and while its quotient is applied.
// The four-entry queue keeps accepting input during that hold and during output
// stalls until it is full.
// Reset is synchronous and clears calibration state; the one-g register returns to 16384.
`timescale 1ns / 1ps

module imu_offset_calibrate_correct import imuocc_pkg::*; #(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [SAMPLE_BITS-1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accel_x_corr, accel_y_corr, accel_z_corr, gyro_x_corr, gyro_y_corr, gyro_z_corr
  output logic [SAMPLE_BITS-1:0] out_tdata,
  // gyro_calibrated, accel_calibrated
  output logic [1:0]             out_tuser,
  input  logic                   cfg_we,
  input  logic [ONE_G_W-1:0]     cfg_wdata
);

  logic  full;
  logic  push;
  logic  pop;
  logic  head_valid;
  cls_t  cls;
  qent_t ent;
  qent_t head;

  assign in_tready = !full;
  assign push      = in_tvalid && in_tready;

  assign ent.cls   = cls;
  assign ent.accel = in_tdata[N_AXES*SMP_W-1:0];
  assign ent.gyro  = in_tdata[SAMPLE_BITS-1:N_AXES*SMP_W];

  imuocc_front #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .cls   (cls)
  );

  imuocc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (ent),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  imuocc_back #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> design/imuocc_chk.sv
// Port-level checks for the IMU offset calibration block, bound to the top level.
`timescale 1ns / 1ps

module imuocc_chk import imuocc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [SAMPLE_BITS-1:0] out_tdata,
  input logic [1:0]             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_accel_after_gyro: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("accel calibrated before gyro");

  a_gyro_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(out_tvalid) && $past(out_tuser[0]) |-> out_tuser[0])
    else $error("gyro calibrated flag cleared");

  a_accel_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(out_tvalid) && $past(out_tuser[1]) |-> out_tuser[1])
    else $error("accel calibrated flag cleared");

endmodule

bind imu_offset_calibrate_correct imuocc_chk u_chk (.*);
